### src/sbl_pkg.sv
// ----------------------------------------------------------------------------
// sbl_pkg
// Shared types, constants and helper functions of the spectrum bar encoder.
// ----------------------------------------------------------------------------
package sbl_pkg;

  // fixed field widths
  localparam int COLUMN_W  = 3;
  localparam int HEIGHT_W  = 8;
  localparam int LED_IDX_W = 6;
  localparam int CODE_W    = 32;
  localparam int NIBBLE_W  = 4;
  localparam int COLOUR_W  = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  // size defaults
  localparam int ROW_COUNT_DEF    = 8;
  localparam int COLUMN_COUNT_DEF = 8;
  localparam int LED_COUNT_DEF    = 64;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ONE_BIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_BIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT   = 2'd2;

  // register reset values
  localparam logic [NIBBLE_W-1:0] ONE_BIT_RST  = 4'd14;
  localparam logic [NIBBLE_W-1:0] ZERO_BIT_RST = 4'd8;
  localparam logic [COLOUR_W-1:0] BRIGHT_RST   = 8'd40;

  // full colour scale
  localparam int COLOUR_MAX = 255;

  // one result transaction
  typedef struct packed {
    logic [LED_IDX_W-1:0] led_addr;
    logic                 in_range;
    logic [CODE_W-1:0]    green_code;
    logic [CODE_W-1:0]    red_code;
    logic [CODE_W-1:0]    blue_code;
    logic                 last_row;
  } sbl_result_t;

  // component * cap / 255, rounded down; product stays below 2^16
  function automatic logic [COLOUR_W-1:0] scale_colour(input logic [COLOUR_W-1:0] c,
                                                       input logic [COLOUR_W-1:0] cap);
    logic [15:0] prod;
    logic [16:0] sum;
    prod = {8'd0, c} * {8'd0, cap};
    sum  = {1'b0, prod} + 17'(prod >> 8) + 17'd1;
    return sum[15:8];
  endfunction

  // one spi nibble per colour bit, msb first in the top nibble
  function automatic logic [CODE_W-1:0] encode_byte(input logic [COLOUR_W-1:0] v,
                                                    input logic [NIBBLE_W-1:0] one_pat,
                                                    input logic [NIBBLE_W-1:0] zero_pat);
    logic [CODE_W-1:0] code;
    code = '0;
    for (int b = 0; b < COLOUR_W; b++) begin
      code[b*NIBBLE_W +: NIBBLE_W] = v[b] ? one_pat : zero_pat;
    end
    return code;
  endfunction

endpackage

### src/sbl_row_seq.sv
// ----------------------------------------------------------------------------
// sbl_row_seq
// Holds the current column and steps a row counter, one row per free slot.
// ----------------------------------------------------------------------------
module sbl_row_seq #(
  parameter int ROW_COUNT = sbl_pkg::ROW_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  logic [sbl_pkg::COLUMN_W-1:0]        column_index,
  input  logic [sbl_pkg::HEIGHT_W-1:0]        bar_height,
  input  logic                                space,
  output logic                                busy,
  output logic                                advance,
  output logic [sbl_pkg::COLUMN_W-1:0]        column,
  output logic [$clog2(ROW_COUNT+1)-1:0]      height,
  output logic [$clog2(ROW_COUNT)-1:0]        row
);
  import sbl_pkg::*;

  localparam int ROW_W = $clog2(ROW_COUNT);
  localparam int HGT_W = $clog2(ROW_COUNT + 1);

  logic last;
  logic take;

  assign last       = (row == ROW_W'(ROW_COUNT - 1));
  assign advance    = busy && space;
  assign item_ready = !busy || (advance && last);
  assign take       = item_valid && item_ready;

  // control: busy flag and row counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      row  <= '0;
    end else if (take) begin
      busy <= 1'b1;
      row  <= '0;
    end else if (advance) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        row <= row + ROW_W'(1);
      end
    end
  end

  // column payload, height saturated at the row count
  always_ff @(posedge clk) begin
    if (take) begin
      column <= column_index;
      height <= (bar_height > HEIGHT_W'(ROW_COUNT)) ? HGT_W'(ROW_COUNT)
                                                    : HGT_W'(bar_height);
    end
  end

endmodule

### src/sbl_pixel.sv
// ----------------------------------------------------------------------------
// sbl_pixel
// Colour gradient, brightness scale and nibble encoding of one row.
// ----------------------------------------------------------------------------
module sbl_pixel #(
  parameter int ROW_COUNT    = sbl_pkg::ROW_COUNT_DEF,
  parameter int COLUMN_COUNT = sbl_pkg::COLUMN_COUNT_DEF,
  parameter int LED_COUNT    = sbl_pkg::LED_COUNT_DEF
) (
  input  logic [sbl_pkg::COLUMN_W-1:0]   column,
  input  logic [$clog2(ROW_COUNT+1)-1:0] height,
  input  logic [$clog2(ROW_COUNT)-1:0]   row,
  input  logic [sbl_pkg::NIBBLE_W-1:0]   one_bit_pattern,
  input  logic [sbl_pkg::NIBBLE_W-1:0]   zero_bit_pattern,
  input  logic [sbl_pkg::COLOUR_W-1:0]   brightness_cap,
  output sbl_pkg::sbl_result_t           result
);
  import sbl_pkg::*;

  localparam int ROW_W   = $clog2(ROW_COUNT);
  localparam int HGT_W   = $clog2(ROW_COUNT + 1);
  localparam int IDX_MAX = (1 << COLUMN_W) - 1 + (ROW_COUNT - 1) * ROW_COUNT;
  localparam int IDX_LIM = (IDX_MAX > LED_COUNT) ? IDX_MAX : LED_COUNT;
  localparam int IDX_W   = $clog2(IDX_LIM + 1);

  logic [COLOUR_W-1:0] red_tab   [ROW_COUNT];
  logic [COLOUR_W-1:0] green_tab [ROW_COUNT];
  logic [COLOUR_W-1:0] red_raw;
  logic [COLOUR_W-1:0] green_raw;
  logic [COLOUR_W-1:0] blue_raw;
  logic [COLOUR_W-1:0] red;
  logic [COLOUR_W-1:0] green;
  logic [COLOUR_W-1:0] blue;
  logic                lit;
  logic [IDX_W-1:0]    idx;

  // per-row gradient table, worked out at elaboration
  for (genvar r = 0; r < ROW_COUNT; r++) begin : g_grad
    localparam int T    = (r * COLOUR_MAX) / (ROW_COUNT - 1);
    localparam int DIFF = (2 * T > COLOUR_MAX) ? (2 * T - COLOUR_MAX) : (COLOUR_MAX - 2 * T);
    assign red_tab[r]   = COLOUR_W'(T);
    assign green_tab[r] = COLOUR_W'(COLOUR_MAX - DIFF);
  end

  assign red_raw   = red_tab[row];
  assign green_raw = green_tab[row];
  assign blue_raw  = ~red_raw;

  // rows below the bar are lit, the rest stay dark
  assign lit   = HGT_W'(row) < height;
  assign red   = lit ? scale_colour(red_raw, brightness_cap)   : '0;
  assign green = lit ? scale_colour(green_raw, brightness_cap) : '0;
  assign blue  = lit ? scale_colour(blue_raw, brightness_cap)  : '0;

  // led position in the strip
  assign idx = IDX_W'(column) + IDX_W'(row) * IDX_W'(ROW_COUNT);

  always_comb begin
    result.led_addr   = LED_IDX_W'(idx);
    result.in_range   = (int'(column) < COLUMN_COUNT) && (idx < IDX_W'(LED_COUNT));
    result.green_code = encode_byte(green, one_bit_pattern, zero_bit_pattern);
    result.red_code   = encode_byte(red, one_bit_pattern, zero_bit_pattern);
    result.blue_code  = encode_byte(blue, one_bit_pattern, zero_bit_pattern);
    result.last_row   = (row == ROW_W'(ROW_COUNT - 1));
  end

endmodule

### src/sbl_out_reg.sv
// ----------------------------------------------------------------------------
// sbl_out_reg
// Result register; takes a new row whenever it is empty or being drained.
// ----------------------------------------------------------------------------
module sbl_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  sbl_pkg::sbl_result_t result_in,
  output logic                 space,
  output logic                 result_valid,
  input  logic                 result_ready,
  output sbl_pkg::sbl_result_t result_q
);
  import sbl_pkg::*;

  assign space = !result_valid || result_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (space) begin
      result_valid <= load;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (space && load) begin
      result_q <= result_in;
    end
  end

endmodule

### src/spectrum_bar_led_encoder.sv
// ----------------------------------------------------------------------------
// spectrum_bar_led_encoder
// Turns one spectrum column into one encoded led colour per row.
//
//   channel  direction  signals
//   item     in         item_valid, item_ready, column_index, bar_height
//   result   out        result_valid, result_ready, led_addr .. last_row
//   cfg      in         cfg_valid, cfg_ready, cfg_index, cfg_data
//
// Each column gives ROW_COUNT results, one per cycle while the result is
// not stalled, paced by the row counter; the next column is taken in the
// cycle its last row is issued. A taken column is registered in the row
// sequencer, then its first result in the output register. A stalled
// result holds the output register and the row counter. Reset clears the
// control flags and loads the register defaults; cfg is always ready.
// ----------------------------------------------------------------------------
module spectrum_bar_led_encoder #(
  parameter int ROW_COUNT    = sbl_pkg::ROW_COUNT_DEF,
  parameter int COLUMN_COUNT = sbl_pkg::COLUMN_COUNT_DEF,
  parameter int LED_COUNT    = sbl_pkg::LED_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  logic [sbl_pkg::COLUMN_W-1:0]    column_index,
  input  logic [sbl_pkg::HEIGHT_W-1:0]    bar_height,
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic [sbl_pkg::LED_IDX_W-1:0]   led_addr,
  output logic                            in_range,
  output logic [sbl_pkg::CODE_W-1:0]      green_code,
  output logic [sbl_pkg::CODE_W-1:0]      red_code,
  output logic [sbl_pkg::CODE_W-1:0]      blue_code,
  output logic                            last_row,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sbl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sbl_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sbl_pkg::*;

  localparam int ROW_W = $clog2(ROW_COUNT);
  localparam int HGT_W = $clog2(ROW_COUNT + 1);

  logic [NIBBLE_W-1:0] one_bit_pattern;
  logic [NIBBLE_W-1:0] zero_bit_pattern;
  logic [COLOUR_W-1:0] brightness_cap;

  logic                busy;
  logic                advance;
  logic                space;
  logic [COLUMN_W-1:0] cur_column;
  logic [HGT_W-1:0]    cur_height;
  logic [ROW_W-1:0]    cur_row;
  sbl_result_t         pixel;
  sbl_result_t         result_q;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      one_bit_pattern  <= ONE_BIT_RST;
      zero_bit_pattern <= ZERO_BIT_RST;
      brightness_cap   <= BRIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ONE_BIT:  one_bit_pattern  <= cfg_data[NIBBLE_W-1:0];
        REG_ZERO_BIT: zero_bit_pattern <= cfg_data[NIBBLE_W-1:0];
        REG_BRIGHT:   brightness_cap   <= cfg_data[COLOUR_W-1:0];
        default: ;
      endcase
    end
  end

  // row sequencer
  sbl_row_seq #(
    .ROW_COUNT (ROW_COUNT)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .column_index (column_index),
    .bar_height   (bar_height),
    .space        (space),
    .busy         (busy),
    .advance      (advance),
    .column       (cur_column),
    .height       (cur_height),
    .row          (cur_row)
  );

  // colour and encoding of the current row
  sbl_pixel #(
    .ROW_COUNT    (ROW_COUNT),
    .COLUMN_COUNT (COLUMN_COUNT),
    .LED_COUNT    (LED_COUNT)
  ) u_pixel (
    .column           (cur_column),
    .height           (cur_height),
    .row              (cur_row),
    .one_bit_pattern  (one_bit_pattern),
    .zero_bit_pattern (zero_bit_pattern),
    .brightness_cap   (brightness_cap),
    .result           (pixel)
  );

  // result register
  sbl_out_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (busy),
    .result_in    (pixel),
    .space        (space),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_q     (result_q)
  );

  assign led_addr   = result_q.led_addr;
  assign in_range   = result_q.in_range;
  assign green_code = result_q.green_code;
  assign red_code   = result_q.red_code;
  assign blue_code  = result_q.blue_code;
  assign last_row   = result_q.last_row;

  // a column transaction always starts at the bottom row
  a_start_row: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> busy && (cur_row == '0))
    else $error("new column did not start at row zero");

  // issuing the top row leaves the sequencer idle unless a column was taken
  a_column_end: assert property (@(posedge clk) disable iff (rst)
    advance && pixel.last_row |=> !busy || $past(item_valid))
    else $error("sequencer still busy after the top row");

  // an empty bar gives dark rows made of zero-bit nibbles only
  a_dark_row: assert property (@(posedge clk) disable iff (rst)
    advance && (cur_height == '0) |=>
      (red_code == {8{$past(zero_bit_pattern)}}) &&
      (green_code == {8{$past(zero_bit_pattern)}}) &&
      (blue_code == {8{$past(zero_bit_pattern)}}))
    else $error("unlit row carries colour");

  // a column past the column count never marks a write
  a_bad_column: assert property (@(posedge clk) disable iff (rst)
    advance && (int'(cur_column) >= COLUMN_COUNT) |=> !in_range)
    else $error("out of range column flagged in range");

endmodule
